// ----- hw/rtl/idbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval double-booking table package
// Shared sizes, types and status codes for the booking table and its parts.
// ----------------------------------------------------------------------------
package idbt_pkg;

  // Table sizes and time width.
  localparam int unsigned BOOKING_DEPTH = 64;
  localparam int unsigned OVERLAP_DEPTH = 64;
  localparam int unsigned TIME_BITS     = 32;

  // Fixed widths of the stream fields.
  localparam int unsigned SLOT_BITS  = 32;
  localparam int unsigned IN_DATA_W  = 2 * SLOT_BITS;
  localparam int unsigned OUT_DATA_W = 8;

  // Index and counter widths derived from the depths.
  localparam int unsigned BIDX_W  = (BOOKING_DEPTH > 1) ? $clog2(BOOKING_DEPTH) : 1;
  localparam int unsigned OIDX_W  = (OVERLAP_DEPTH > 1) ? $clog2(OVERLAP_DEPTH) : 1;
  localparam int unsigned BCNT_W  = $clog2(BOOKING_DEPTH + 1);
  localparam int unsigned OCNT_W  = $clog2(OVERLAP_DEPTH + 1);
  localparam int unsigned SCNT_W  = (BCNT_W > OCNT_W) ? BCNT_W : OCNT_W;
  localparam int unsigned SUM_W   = SCNT_W + 1;
  localparam int unsigned ENTRY_W = 2 * TIME_BITS;

  // Count limits at the widths they are compared at.
  localparam logic [BCNT_W-1:0] BKD_LIMIT = BCNT_W'(BOOKING_DEPTH);
  localparam logic [SUM_W-1:0]  DBL_LIMIT = SUM_W'(OVERLAP_DEPTH);

  typedef logic [TIME_BITS-1:0] time_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_TRIPLE   = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  // Output of the shared intersection unit.
  typedef struct packed {
    logic  hit;
    time_t lo;
    time_t hi;
  } isect_t;

endpackage

// ----- hw/rtl/interval_double_booking_table.sv -----
// ----------------------------------------------------------------------------
// Interval double-booking table
// Books half-open intervals and refuses any that would cause a triple booking.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the slave stream as one transfer carrying the interval
// [slot_start, slot_stop). One result transfer per request leaves on the
// master stream with a granted flag and a two-bit status (accepted, triple
// overlap, table full, empty interval).
// A request walks the overlap table and then the booking table through one
// read port each, one entry a cycle, into a single intersection unit. A
// triple overlap ends the walk early, and an empty interval skips both
// walks and goes straight to the result stage. The block takes one
// request at a time and is not ready while a request is in work.
// A finished result sits in an output register, so the next request may be
// accepted while the receiver stalls; only the following result then waits.
// Reset empties both tables at once by clearing their fill counts; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_double_booking_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: slot_start [31:0], slot_stop [63:32]
  input  logic [idbt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: granted [0], status [2:1], zero [7:3]
  output logic [idbt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import idbt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_DBL,
    ST_SCAN_BKD,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  time_t               req_lo_q, req_lo_d;
  time_t               req_hi_q, req_hi_d;
  logic [SCNT_W-1:0]   idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [BCNT_W-1:0]   fresh_q, fresh_d;
  logic [BCNT_W-1:0]   bkd_cnt_q, bkd_cnt_d;
  logic [OCNT_W-1:0]   dbl_cnt_q, dbl_cnt_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;

  time_t               in_lo;
  time_t               in_hi;
  logic [SCNT_W-1:0]   scan_lim;
  logic                scanning;
  logic                issue;
  logic [SUM_W-1:0]    dbl_sum;
  logic                dbl_we;
  logic                bkd_we;
  logic                out_load;
  logic                full;
  logic [ENTRY_W-1:0]  dbl_rdata;
  logic [ENTRY_W-1:0]  bkd_rdata;
  logic [ENTRY_W-1:0]  ent;
  isect_t              isect;

  // Request fields in the table's time width.
  assign in_lo = time_t'(s_axis_tdata[SLOT_BITS-1:0]);
  assign in_hi = time_t'(s_axis_tdata[IN_DATA_W-1:SLOT_BITS]);

  // Read issue for the current scan; read data is registered and returns in the next cycle.
  assign scanning = (state_q == ST_SCAN_DBL) || (state_q == ST_SCAN_BKD);
  assign scan_lim = (state_q == ST_SCAN_DBL) ? SCNT_W'(dbl_cnt_q) : SCNT_W'(bkd_cnt_q);
  assign issue    = scanning && (idx_q < scan_lim);

  // Overlaps are written beyond the committed count while the booking table
  // is scanned; the count only moves if the whole request is granted.
  assign dbl_sum = SUM_W'(dbl_cnt_q) + SUM_W'(fresh_q);
  assign dbl_we  = (state_q == ST_SCAN_BKD) && pend_q && isect.hit && (dbl_sum < DBL_LIMIT);
  assign full    = (bkd_cnt_q >= BKD_LIMIT) || (dbl_sum > DBL_LIMIT);
  assign bkd_we  = (state_q == ST_DECIDE) && !full;

  // Result register loads when empty or being drained.
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Overlap table: entries hold {stop, start}.
  idbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (OVERLAP_DEPTH),
    .ADDR_W(OIDX_W)
  ) u_dbl_ram (
    .clk_i  (clk_i),
    .we_i   (dbl_we),
    .waddr_i(dbl_sum[OIDX_W-1:0]),
    .wdata_i({isect.hi, isect.lo}),
    .re_i   (issue && (state_q == ST_SCAN_DBL)),
    .raddr_i(idx_q[OIDX_W-1:0]),
    .rdata_o(dbl_rdata)
  );

  // Booking table: entries hold {stop, start}.
  idbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BOOKING_DEPTH),
    .ADDR_W(BIDX_W)
  ) u_bkd_ram (
    .clk_i  (clk_i),
    .we_i   (bkd_we),
    .waddr_i(bkd_cnt_q[BIDX_W-1:0]),
    .wdata_i({req_hi_q, req_lo_q}),
    .re_i   (issue && (state_q == ST_SCAN_BKD)),
    .raddr_i(idx_q[BIDX_W-1:0]),
    .rdata_o(bkd_rdata)
  );

  // One intersection unit serves both scans.
  assign ent = (state_q == ST_SCAN_DBL) ? dbl_rdata : bkd_rdata;

  idbt_isect u_isect (
    .req_lo_i(req_lo_q),
    .req_hi_i(req_hi_q),
    .ent_lo_i(ent[TIME_BITS-1:0]),
    .ent_hi_i(ent[ENTRY_W-1:TIME_BITS]),
    .res_o   (isect)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    req_lo_d     = req_lo_q;
    req_hi_d     = req_hi_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    fresh_d      = fresh_q;
    bkd_cnt_d    = bkd_cnt_q;
    dbl_cnt_d    = dbl_cnt_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_lo_d = in_lo;
          req_hi_d = in_hi;
          idx_d    = '0;
          pend_d   = 1'b0;
          if (in_lo >= in_hi) begin
            res_status_d = STATUS_EMPTY;
            state_d      = ST_EMIT;
          end else begin
            state_d = ST_SCAN_DBL;
          end
        end
      end
      ST_SCAN_DBL: begin
        pend_d = issue;
        idx_d  = issue ? idx_q + 1'b1 : idx_q;
        if (pend_q && isect.hit) begin
          res_status_d = STATUS_TRIPLE;
          pend_d       = 1'b0;
          state_d      = ST_EMIT;
        end else if (!pend_q && !issue) begin
          idx_d   = '0;
          fresh_d = '0;
          state_d = ST_SCAN_BKD;
        end
      end
      ST_SCAN_BKD: begin
        pend_d = issue;
        idx_d  = issue ? idx_q + 1'b1 : idx_q;
        if (pend_q && isect.hit) begin
          fresh_d = fresh_q + 1'b1;
        end
        if (!pend_q && !issue) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (full) begin
          res_status_d = STATUS_FULL;
        end else begin
          res_status_d = STATUS_ACCEPTED;
          dbl_cnt_d    = OCNT_W'(dbl_sum);
          bkd_cnt_d    = bkd_cnt_q + 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, counts and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      bkd_cnt_q   <= '0;
      dbl_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      bkd_cnt_q   <= bkd_cnt_d;
      dbl_cnt_q   <= dbl_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_lo_q     <= req_lo_d;
    req_hi_q     <= req_hi_d;
    idx_q        <= idx_d;
    fresh_q      <= fresh_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
  end

  // Stream ports.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 3){1'b0}}, out_status_q,
                          (out_status_q == STATUS_ACCEPTED)};

  // Assertions.
  a_bkd_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkd_cnt_q <= BKD_LIMIT)
    else $error("booking count beyond table depth");

  a_dbl_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> dbl_cnt_q >= $past(dbl_cnt_q))
    else $error("overlap count decreased");

  a_grant_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bkd_we |=> (state_q == ST_EMIT) && (res_status_q == STATUS_ACCEPTED) &&
               (bkd_cnt_q == $past(bkd_cnt_q) + 1'b1))
    else $error("booking stored without a grant");

  a_hold_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_we |-> (state_q == ST_SCAN_BKD) && !s_axis_tready)
    else $error("overlap write outside the booking scan");

endmodule

// ----- hw/rtl/idbt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module idbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/idbt_isect.sv -----
// ----------------------------------------------------------------------------
// Interval intersection unit
// Compares the request against one table entry and forms the overlap.
// ----------------------------------------------------------------------------
module idbt_isect (
  input  idbt_pkg::time_t  req_lo_i,
  input  idbt_pkg::time_t  req_hi_i,
  input  idbt_pkg::time_t  ent_lo_i,
  input  idbt_pkg::time_t  ent_hi_i,
  output idbt_pkg::isect_t res_o
);
  import idbt_pkg::*;

  time_t lo;
  time_t hi;

  // The overlap is [max of starts, min of stops); it exists only when nonempty.
  always_comb begin
    lo = (req_lo_i > ent_lo_i) ? req_lo_i : ent_lo_i;
    hi = (req_hi_i < ent_hi_i) ? req_hi_i : ent_hi_i;
    res_o.lo  = lo;
    res_o.hi  = hi;
    res_o.hit = (lo < hi);
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval double-booking table testbench
// Streams booking requests into the table and checks every result transfer
// against a booking predictor kept inside the testbench. A directed opening
// covers empty, touching, overlapping and edge-of-range intervals. A random
// part then mixes noise with requests placed around booked intervals. A
// closing part fills the booking table and probes the full-table answers.
// Both stream sides idle at random, and the receiver stalls once for long.
// ----------------------------------------------------------------------------

import idbt_pkg::*;

// Expected result of one request, kept with the request for messages.
typedef struct packed {
  time_t   lo;
  time_t   hi;
  logic    granted;
  status_e status;
} verdict_t;

// Booking predictor and store of expected results.
class booking_scoreboard;
  time_t       booked_lo [BOOKING_DEPTH];
  time_t       booked_hi [BOOKING_DEPTH];
  time_t       double_lo [OVERLAP_DEPTH];
  time_t       double_hi [OVERLAP_DEPTH];
  int unsigned booked_count;
  int unsigned double_count;
  verdict_t    pending_verdicts[$];
  int unsigned errors;

  function bit overlaps(time_t a_lo, time_t a_hi, time_t b_lo, time_t b_hi);
    time_t top_lo;
    time_t low_hi;
    top_lo = (a_lo > b_lo) ? a_lo : b_lo;
    low_hi = (a_hi < b_hi) ? a_hi : b_hi;
    return top_lo < low_hi;
  endfunction

  // Status that a request would get against the current tables; fresh counts
  // the bookings it intersects.
  function status_e judge(time_t lo, time_t hi, output int unsigned fresh);
    fresh = 0;
    if (lo >= hi) return STATUS_EMPTY;
    for (int unsigned i = 0; i < double_count; i++) begin
      if (overlaps(lo, hi, double_lo[i], double_hi[i])) return STATUS_TRIPLE;
    end
    for (int unsigned i = 0; i < booked_count; i++) begin
      if (overlaps(lo, hi, booked_lo[i], booked_hi[i])) fresh++;
    end
    if (booked_count >= BOOKING_DEPTH || double_count + fresh > OVERLAP_DEPTH) begin
      return STATUS_FULL;
    end
    return STATUS_ACCEPTED;
  endfunction

  // Apply an accepted request transfer and queue its expected result.
  function void note_request(time_t lo, time_t hi);
    status_e     st;
    int unsigned fresh;
    int unsigned old_count;
    verdict_t    v;
    st = judge(lo, hi, fresh);
    if (st == STATUS_ACCEPTED) begin
      old_count = booked_count;
      for (int unsigned i = 0; i < old_count; i++) begin
        if (overlaps(lo, hi, booked_lo[i], booked_hi[i]) && double_count < OVERLAP_DEPTH) begin
          double_lo[double_count] = (lo > booked_lo[i]) ? lo : booked_lo[i];
          double_hi[double_count] = (hi < booked_hi[i]) ? hi : booked_hi[i];
          double_count++;
        end
      end
      booked_lo[booked_count] = lo;
      booked_hi[booked_count] = hi;
      booked_count++;
    end
    v.lo      = lo;
    v.hi      = hi;
    v.granted = (st == STATUS_ACCEPTED);
    v.status  = st;
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH @%0t ns: %s", $time, what);
    errors++;
  endtask

  // Compare one result transfer with the oldest expectation.
  task check_verdict(logic [OUT_DATA_W-1:0] data);
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("result %h with no request waiting", data));
      return;
    end
    want = pending_verdicts.pop_front();
    if (data[0] !== want.granted) begin
      report_mismatch($sformatf("[%h,%h) granted %b, expected %b",
                                want.lo, want.hi, data[0], want.granted));
    end
    if (data[2:1] !== want.status) begin
      report_mismatch($sformatf("[%h,%h) status %0d, expected %s",
                                want.lo, want.hi, data[2:1], want.status.name()));
    end
    if (data[OUT_DATA_W-1:3] !== '0) begin
      report_mismatch($sformatf("[%h,%h) padding bits %b not zero",
                                want.lo, want.hi, data[OUT_DATA_W-1:3]));
    end
  endtask
endclass

module tb_top;

  localparam int unsigned RANDOM_REQUESTS = 1830;
  localparam int unsigned HOLD_OFF_CYCLES = 800;
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT     = 4000000;
  localparam int unsigned FILL_TRIES      = 100000;

  // Regions that random requests crowd into: bottom, middle and top of time.
  localparam time_t HOT_BASE [3] = '{32'h0000_0000, 32'h7FFF_F000, 32'hFFFF_E000};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  booking_scoreboard sb = new();
  bit                hold_off_due = 1'b0;
  int unsigned       cycle_count  = 0;

  interval_double_booking_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 160);
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input time_t lo, input time_t hi, input bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(lo, hi);
  endtask

  // Draw a random request: reversed or noise intervals, intervals placed
  // around the ends of existing bookings, or short ones in a crowded region.
  function automatic void draw_slot(output time_t lo, output time_t hi);
    int unsigned kind;
    int unsigned pick;
    time_t       a;
    time_t       b;
    time_t       anchor;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      a  = $urandom;
      b  = $urandom;
      lo = (a > b) ? a : b;
      hi = (a > b) ? b : a;
      if (kind < 3) hi = lo;
    end else if (kind < 13) begin
      lo = $urandom;
      hi = $urandom;
    end else if (kind < 60 && sb.booked_count != 0) begin
      pick   = $urandom_range(0, sb.booked_count - 1);
      anchor = $urandom_range(0, 1) ? sb.booked_lo[pick] : sb.booked_hi[pick];
      lo     = anchor + time_t'($urandom_range(0, 16)) - time_t'(8);
      hi     = lo + time_t'($urandom_range(1, 40));
    end else begin
      lo = HOT_BASE[$urandom_range(0, 2)] + time_t'($urandom_range(0, 4095));
      hi = lo + time_t'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2048)
                                                   : $urandom_range(1, 64));
    end
  endfunction

  // Result side: ready in random spans, one long hold-off on request.
  initial begin : result_sink
    int unsigned span;
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 12);
      repeat (span) @(posedge clk_i);
      gap = idle_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Request stimulus.
  initial begin : request_source
    time_t       lo;
    time_t       hi;
    int unsigned fresh;
    int unsigned tries;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty intervals: equal ends, reversed ends and the widest reversal.
    send_request(32'd5, 32'd5, 1'b0);
    send_request(32'd1, 32'd0, 1'b0);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    // Two bookings that only touch do not overlap.
    send_request(32'd100, 32'd200, 1'b0);
    send_request(32'd200, 32'd300, 1'b0);
    send_request(32'd300, 32'd400, 1'b0);
    // Spanning a touch point leaves one doubly booked region on each side.
    send_request(32'd150, 32'd250, 1'b0);
    // Any point inside a doubly booked region is refused.
    send_request(32'd199, 32'd201, 1'b0);
    // Touching a doubly booked region is not an overlap.
    send_request(32'd250, 32'd260, 1'b0);
    send_request(32'd140, 32'd150, 1'b0);
    // Both ends of the time range.
    send_request(32'd0, 32'd1, 1'b0);
    send_request(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // Random part; the receiver stalls long at its start so the block backs up.
    hold_off_due = 1'b1;
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      // Spread acceptances over the run so the tables fill gradually.
      for (tries = 0; tries < 8; tries++) begin
        draw_slot(lo, hi);
        if (sb.judge(lo, hi, fresh) != STATUS_ACCEPTED) break;
        if ($urandom_range(0, RANDOM_REQUESTS - n) < 2 * (BOOKING_DEPTH - sb.booked_count)) break;
      end
      send_request(lo, hi, (n % 250) < 50);
    end

    // Fill the booking table with short free intervals, looking anywhere in
    // time as well, and give up when no free room turns up.
    for (tries = 0; tries < FILL_TRIES && sb.booked_count < BOOKING_DEPTH; tries++) begin
      if (tries % 2 == 0) begin
        lo = 32'h5000_0000 + time_t'($urandom_range(0, 1 << 20));
      end else begin
        lo = $urandom;
      end
      hi = lo + time_t'($urandom_range(1, 4));
      if (sb.judge(lo, hi, fresh) == STATUS_ACCEPTED) send_request(lo, hi, 1'b0);
    end
    // A full table still answers empty and triple overlap ahead of full.
    send_request(32'h6000_0000, 32'h6000_0010, 1'b0);
    send_request(32'd7, 32'd7, 1'b0);
    if (sb.double_count != 0) send_request(sb.double_lo[0], sb.double_hi[0], 1'b0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the block's latency for any stray result.
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
